### hw/rtl/etfp_pkg.sv
// ----------------------------------------------------------------------------
// etfp_pkg
// Shared types, register indexes and fixed-point helpers of the
// escape-time fractal pixel engine.
// ----------------------------------------------------------------------------
package etfp_pkg;

  localparam int DIM_BITS  = 12;
  localparam int SIZE_BITS = DIM_BITS + 1;
  localparam int ITER_BITS = 16;
  localparam int PROD_BITS = SIZE_BITS + 63;
  localparam int NUM_BITS  = 28;
  localparam int DEN_BITS  = 20;

  localparam logic [63:0] S64_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] S64_MIN = 64'h8000_0000_0000_0000;

  localparam logic [2:0] REG_WIDTH    = 3'd0;
  localparam logic [2:0] REG_HEIGHT   = 3'd1;
  localparam logic [2:0] REG_MAX_ITER = 3'd2;
  localparam logic [2:0] REG_X_OFFSET = 3'd3;
  localparam logic [2:0] REG_Y_OFFSET = 3'd4;
  localparam logic [2:0] REG_STEP_X   = 3'd5;
  localparam logic [2:0] REG_STEP_Y   = 3'd6;

  localparam logic [3:0] COLOR_K [3] = '{4'd9, 4'd3, 4'd6};

  typedef struct packed {
    logic [SIZE_BITS-1:0] width;
    logic [SIZE_BITS-1:0] height;
    logic [ITER_BITS-1:0] max_iter;
    logic [63:0]          x_off;
    logic [63:0]          y_off;
    logic [62:0]          step_x;
    logic [62:0]          step_y;
  } cfg_t;

  typedef struct packed {
    logic [DIM_BITS-1:0] px;
    logic [DIM_BITS-1:0] py;
    logic [63:0]         cx;
    logic [63:0]         cy;
  } item_t;

  typedef enum logic [2:0] {
    F_IDLE, F_MUL_GO, F_MUL_WAIT, F_DIV_WAIT, F_PUSH
  } front_state_t;

  typedef enum logic [2:0] {
    B_IDLE, B_MUL_GO, B_MUL_WAIT, B_UPD, B_COLOR_WAIT, B_OUT
  } core_state_t;

  function automatic logic [63:0] sat_add(logic [63:0] a, logic [63:0] b);
    logic [63:0] s;
    s = a + b;
    if (a[63] == b[63] && s[63] != a[63]) return a[63] ? S64_MIN : S64_MAX;
    return s;
  endfunction

  // off +/- quotient, floored, clamped to signed 64 bits
  function automatic logic [63:0] map_finish(logic [PROD_BITS-1:0] q, logic rnz,
                                             logic neg, logic [63:0] off);
    logic [66:0] a;
    logic [66:0] o;
    logic [66:0] s;
    if (q[PROD_BITS-1:64] != '0) return neg ? S64_MIN : S64_MAX;
    a = {3'b000, q[63:0]} + {66'd0, neg & rnz};
    o = {{3{off[63]}}, off};
    s = neg ? o - a : o + a;
    if ($signed(s) > $signed({3'b000, S64_MAX})) return S64_MAX;
    if ($signed(s) < $signed({3'b111, S64_MIN})) return S64_MIN;
    return s[63:0];
  endfunction

endpackage

### hw/rtl/etfp_if.sv
// ----------------------------------------------------------------------------
// etfp_if
// Channel interfaces: pixel requests, pixel results, register writes.
// ----------------------------------------------------------------------------
interface etfp_pix_if import etfp_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [DIM_BITS-1:0] pixel_x;
  logic [DIM_BITS-1:0] pixel_y;
  modport source (output valid, pixel_x, pixel_y, input ready);
  modport sink   (input valid, pixel_x, pixel_y, output ready);
endinterface

interface etfp_res_if import etfp_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [DIM_BITS-1:0]  out_x;
  logic [DIM_BITS-1:0]  out_y;
  logic [7:0]           red;
  logic [7:0]           green;
  logic [7:0]           blue;
  logic [ITER_BITS-1:0] iteration_count;
  logic                 inside_set;
  modport source (output valid, out_x, out_y, red, green, blue, iteration_count,
                  inside_set, input ready);
  modport sink   (input valid, out_x, out_y, red, green, blue, iteration_count,
                  inside_set, output ready);
endinterface

interface etfp_cfg_if import etfp_pkg::*; ();
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [63:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### hw/rtl/etfp_mul.sv
// ----------------------------------------------------------------------------
// etfp_mul
// 64x64 unsigned multiplier, one 32x32 partial product per cycle.
// ----------------------------------------------------------------------------
module etfp_mul (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [63:0]  a,
  input  logic [63:0]  b,
  output logic         done,
  output logic [127:0] prod
);

  logic        run;
  logic [1:0]  cnt;
  logic [63:0] a_r;
  logic [63:0] b_r;
  logic [63:0] pp;
  logic [1:0]  sh;

  assign pp = (cnt[1] ? a_r[63:32] : a_r[31:0]) * (cnt[0] ? b_r[63:32] : b_r[31:0]);
  assign sh = {1'b0, cnt[1]} + {1'b0, cnt[0]};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= 2'd0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= 2'd0;
      end else if (run) begin
        cnt <= cnt + 2'd1;
        if (cnt == 2'd3) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r  <= a;
      b_r  <= b;
      prod <= '0;
    end else if (run) begin
      prod <= prod + ({64'd0, pp} << {sh, 5'd0});
    end
  end

endmodule

### hw/rtl/etfp_div.sv
// ----------------------------------------------------------------------------
// etfp_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module etfp_div #(
  parameter int NW = 28,
  parameter int DW = 20
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] dividend,
  input  logic [DW-1:0] divisor,
  output logic          done,
  output logic [NW-1:0] quo,
  output logic [DW-1:0] rem
);

  localparam int CW = $clog2(NW + 1);

  logic          run;
  logic [CW-1:0] cnt;
  logic [NW-1:0] q;
  logic [DW-1:0] r;
  logic [DW-1:0] d;
  logic [DW:0]   trial;
  logic          fits;

  assign trial = {r, q[NW-1]};
  assign fits  = trial >= {1'b0, d};
  assign quo   = q;
  assign rem   = r;

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= '0;
      end else if (run) begin
        cnt <= cnt + 1'b1;
        if (cnt == CW'(NW - 1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q <= dividend;
      r <= '0;
      d <= divisor;
    end else if (run) begin
      q <= {q[NW-2:0], fits};
      r <= fits ? DW'(trial - {1'b0, d}) : trial[DW-1:0];
    end
  end

endmodule

### hw/rtl/etfp_front.sv
// ----------------------------------------------------------------------------
// etfp_front
// Accepts pixels and maps both coordinates onto the complex plane.
// ----------------------------------------------------------------------------
module etfp_front import etfp_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  etfp_pix_if.sink      pix,
  input  cfg_t          cfg,
  output logic          q_valid,
  input  logic          q_ready,
  output item_t         q_item
);

  front_state_t state, state_next;

  logic [DIM_BITS-1:0]  px;
  logic [DIM_BITS-1:0]  py;
  logic [63:0]          cx;
  logic [63:0]          cy;
  logic                 sel;

  logic [DIM_BITS-1:0]  p;
  logic [SIZE_BITS-1:0] n;
  logic [SIZE_BITS-1:0] nz;
  logic [SIZE_BITS-1:0] two_p;
  logic                 neg;
  logic [SIZE_BITS-1:0] ad;
  logic [62:0]          step;
  logic [63:0]          off;

  logic                 mul_start;
  logic                 mul_done;
  logic [127:0]         mul_prod;
  logic                 div_start;
  logic                 div_done;
  logic [PROD_BITS-1:0] div_quo;
  logic [SIZE_BITS-1:0] div_rem;
  logic [63:0]          coord;

  assign p     = sel ? py : px;
  assign n     = sel ? cfg.height : cfg.width;
  assign nz    = (n == '0) ? SIZE_BITS'(1) : n;
  assign two_p = {p, 1'b0};
  assign neg   = two_p < nz;
  assign ad    = neg ? nz - two_p : two_p - nz;
  assign step  = sel ? cfg.step_y : cfg.step_x;
  assign off   = sel ? cfg.y_off : cfg.x_off;
  assign coord = map_finish(div_quo, |div_rem, neg, off);

  assign mul_start = (state == F_MUL_GO);
  assign div_start = (state == F_MUL_WAIT) && mul_done;

  etfp_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     ({{(64-SIZE_BITS){1'b0}}, ad}),
    .b     ({1'b0, step}),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  etfp_div #(.NW(PROD_BITS), .DW(SIZE_BITS)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (mul_prod[PROD_BITS-1:0]),
    .divisor  (nz),
    .done     (div_done),
    .quo      (div_quo),
    .rem      (div_rem)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    pix.ready  = 1'b0;
    q_valid    = 1'b0;
    unique case (state)
      F_IDLE: begin
        pix.ready = 1'b1;
        if (pix.valid) state_next = F_MUL_GO;
      end
      F_MUL_GO:   state_next = F_MUL_WAIT;
      F_MUL_WAIT: if (mul_done) state_next = F_DIV_WAIT;
      F_DIV_WAIT: if (div_done) state_next = sel ? F_PUSH : F_MUL_GO;
      F_PUSH: begin
        q_valid = 1'b1;
        if (q_ready) state_next = F_IDLE;
      end
      default: state_next = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == F_IDLE && pix.valid) begin
      px  <= pix.pixel_x;
      py  <= pix.pixel_y;
      sel <= 1'b0;
    end else if (state == F_DIV_WAIT && div_done) begin
      if (sel) begin
        cy <= coord;
      end else begin
        cx  <= coord;
        sel <= 1'b1;
      end
    end
  end

  assign q_item = '{px: px, py: py, cx: cx, cy: cy};

endmodule

### hw/rtl/etfp_queue.sv
// ----------------------------------------------------------------------------
// etfp_queue
// Two-entry queue between the coordinate front end and the iteration core.
// ----------------------------------------------------------------------------
module etfp_queue import etfp_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push_valid,
  output logic  push_ready,
  input  item_t push_item,
  output logic  pop_valid,
  input  logic  pop_ready,
  output item_t pop_item
);

  item_t      mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  logic       pop;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_item   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_item;
  end

endmodule

### hw/rtl/etfp_core.sv
// ----------------------------------------------------------------------------
// etfp_core
// Runs the z = z^2 + c iteration and derives the pixel color.
// ----------------------------------------------------------------------------
module etfp_core import etfp_pkg::*; #(
  parameter int FRAC_BITS = 58
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 q_valid,
  output logic                 q_ready,
  input  item_t                q_item,
  input  logic [ITER_BITS-1:0] max_iter,
  etfp_res_if.source           res
);

  localparam logic [64:0] LIM4 = 65'd4 << FRAC_BITS;

  core_state_t state, state_next;

  item_t                item;
  logic [63:0]          zx;
  logic [63:0]          zy;
  logic [ITER_BITS-1:0] it;
  logic [ITER_BITS-1:0] lim;
  logic [7:0]           col [3];

  logic [63:0]          mag_x;
  logic [63:0]          mag_y;
  logic                 mul_start;
  logic [2:0]           mul_done;
  logic [127:0]         prod_xx;
  logic [127:0]         prod_yy;
  logic [127:0]         prod_xy;

  logic [63:0]          sx;
  logic [63:0]          sy;
  logic                 esc;
  logic [63:0]          nx;
  logic                 cr_neg;
  logic                 cr_frac;
  logic [63:0]          cr_mag;
  logic [64:0]          cr_inc;
  logic [63:0]          cr;
  logic [63:0]          ny;
  logic                 it_end;
  logic                 in_set;

  logic                 col_start;
  logic [2:0]           div_done;
  logic [NUM_BITS-1:0]  num;
  logic [DEN_BITS-1:0]  ti;
  logic [DEN_BITS-1:0]  den [3];
  logic [NUM_BITS-1:0]  quo [3];

  assign mag_x  = zx[63] ? 64'd0 - zx : zx;
  assign mag_y  = zy[63] ? 64'd0 - zy : zy;
  assign it_end = (it == lim);
  assign in_set = it_end;

  assign mul_start = (state == B_MUL_GO) && !it_end;

  etfp_mul u_mul_xx (.clk(clk), .rst(rst), .start(mul_start), .a(mag_x), .b(mag_x),
                     .done(mul_done[0]), .prod(prod_xx));
  etfp_mul u_mul_yy (.clk(clk), .rst(rst), .start(mul_start), .a(mag_y), .b(mag_y),
                     .done(mul_done[1]), .prod(prod_yy));
  etfp_mul u_mul_xy (.clk(clk), .rst(rst), .start(mul_start), .a(mag_x), .b(mag_y),
                     .done(mul_done[2]), .prod(prod_xy));

  always_comb begin
    sx = (|prod_xx[127:FRAC_BITS+64]) ? '1 : prod_xx[FRAC_BITS+63 -: 64];
    sy = (|prod_yy[127:FRAC_BITS+64]) ? '1 : prod_yy[FRAC_BITS+63 -: 64];
    esc = ({1'b0, sx} + {1'b0, sy}) >= LIM4;
    nx  = sat_add(sx - sy, item.cx);

    cr_neg  = zx[63] ^ zy[63];
    cr_frac = |prod_xy[FRAC_BITS-2:0];
    cr_mag  = prod_xy[FRAC_BITS+62 -: 64];
    cr_inc  = {1'b0, cr_mag} + {64'd0, cr_frac};
    if (|prod_xy[127:FRAC_BITS+63]) begin
      cr = cr_neg ? S64_MIN : S64_MAX;
    end else if (!cr_neg) begin
      cr = cr_mag[63] ? S64_MAX : cr_mag;
    end else if (cr_inc >= {1'b0, S64_MIN}) begin
      cr = S64_MIN;
    end else begin
      cr = 64'd0 - cr_inc[63:0];
    end
    ny = sat_add(cr, item.cy);
  end

  assign col_start = ((state == B_MUL_GO) && it_end) || ((state == B_UPD) && esc);
  assign num       = NUM_BITS'(lim) * NUM_BITS'(2550);
  assign ti        = DEN_BITS'(it) * DEN_BITS'(10);

  for (genvar k = 0; k < 3; k++) begin : g_chan
    logic [DEN_BITS-1:0] km;
    assign km     = DEN_BITS'(lim) * DEN_BITS'(COLOR_K[k]);
    assign den[k] = (km > ti) ? km - ti : ti - km;

    etfp_div #(.NW(NUM_BITS), .DW(DEN_BITS)) u_div (
      .clk      (clk),
      .rst      (rst),
      .start    (col_start),
      .dividend (num),
      .divisor  (den[k]),
      .done     (div_done[k]),
      .quo      (quo[k]),
      .rem      ()
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    q_ready    = 1'b0;
    unique case (state)
      B_IDLE: begin
        q_ready = 1'b1;
        if (q_valid) state_next = B_MUL_GO;
      end
      B_MUL_GO:     state_next = it_end ? B_COLOR_WAIT : B_MUL_WAIT;
      B_MUL_WAIT:   if (mul_done[0]) state_next = B_UPD;
      B_UPD:        state_next = esc ? B_COLOR_WAIT : B_MUL_GO;
      B_COLOR_WAIT: if (div_done[0]) state_next = B_OUT;
      B_OUT:        if (!res.valid || res.ready) state_next = B_IDLE;
      default:      state_next = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == B_IDLE && q_valid) begin
      item <= q_item;
      zx   <= '0;
      zy   <= '0;
      it   <= '0;
      lim  <= max_iter;
    end else if (state == B_UPD && !esc) begin
      zx <= nx;
      zy <= ny;
      it <= it + 1'b1;
    end
    if (state == B_COLOR_WAIT && div_done[0]) begin
      for (int k = 0; k < 3; k++) begin
        col[k] <= (in_set || den[k] == '0) ? 8'd0 : quo[k][7:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (state == B_OUT && (!res.valid || res.ready)) begin
      res.valid <= 1'b1;
    end else if (res.ready) begin
      res.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == B_OUT && (!res.valid || res.ready)) begin
      res.out_x           <= item.px;
      res.out_y           <= item.py;
      res.red             <= col[0];
      res.green           <= col[1];
      res.blue            <= col[2];
      res.iteration_count <= it;
      res.inside_set      <= in_set;
    end
  end

endmodule

### hw/rtl/escape_time_fractal_pixel_top.sv
// ----------------------------------------------------------------------------
// escape_time_fractal_pixel_top
// Escape-time fractal pixel engine: coordinate mapping, iteration, coloring.
// ----------------------------------------------------------------------------
// Coordinate mapping runs two 76-bit serial divides, each iteration runs
// the serial multipliers, and coloring runs three 28-bit serial divides.
// The front end maps the next pixel while the core iterates, through the
// two-entry queue; the serial-multiplier iteration loop limits throughput.
// Reset: registers return to an 800x600 view, limit 256; the queue is empty.
// ----------------------------------------------------------------------------
module escape_time_fractal_pixel_top import etfp_pkg::*; #(
  parameter int FRAC_BITS = 58
) (
  input  logic        clk,
  input  logic        rst,
  etfp_pix_if.sink    pix,
  etfp_res_if.source  res,
  etfp_cfg_if.sink    cfg
);

  cfg_t  regs;
  logic  q_in_valid;
  logic  q_in_ready;
  item_t q_in_item;
  logic  q_out_valid;
  logic  q_out_ready;
  item_t q_out_item;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.width    <= SIZE_BITS'(800);
      regs.height   <= SIZE_BITS'(600);
      regs.max_iter <= ITER_BITS'(256);
      regs.x_off    <= 64'hFE00_0000_0000_0000;
      regs.y_off    <= 64'd0;
      regs.step_x   <= 63'd1029394200541827657;
      regs.step_y   <= 63'd772045650406370742;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_WIDTH:    regs.width    <= cfg.data[SIZE_BITS-1:0];
        REG_HEIGHT:   regs.height   <= cfg.data[SIZE_BITS-1:0];
        REG_MAX_ITER: regs.max_iter <= cfg.data[ITER_BITS-1:0];
        REG_X_OFFSET: regs.x_off    <= cfg.data;
        REG_Y_OFFSET: regs.y_off    <= cfg.data;
        REG_STEP_X:   regs.step_x   <= cfg.data[62:0];
        REG_STEP_Y:   regs.step_y   <= cfg.data[62:0];
        default:      regs          <= regs;
      endcase
    end
  end

  etfp_front u_front (
    .clk     (clk),
    .rst     (rst),
    .pix     (pix),
    .cfg     (regs),
    .q_valid (q_in_valid),
    .q_ready (q_in_ready),
    .q_item  (q_in_item)
  );

  etfp_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (q_in_valid),
    .push_ready (q_in_ready),
    .push_item  (q_in_item),
    .pop_valid  (q_out_valid),
    .pop_ready  (q_out_ready),
    .pop_item   (q_out_item)
  );

  etfp_core #(.FRAC_BITS(FRAC_BITS)) u_core (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_out_valid),
    .q_ready  (q_out_ready),
    .q_item   (q_out_item),
    .max_iter (regs.max_iter),
    .res      (res)
  );

endmodule

### verif/pixel_color_checker.sv
// ----------------------------------------------------------------------------
// pixel_color_checker
// Watches the register, request and result channels of the fractal pixel
// engine. It tracks the register file, predicts each pixel's escape count and
// color when the request is accepted, and checks results in order.
// ----------------------------------------------------------------------------
module pixel_color_checker import etfp_pkg::*; (
  input  logic clk,
  input  logic rst,
  etfp_pix_if  pix,
  etfp_res_if  res,
  etfp_cfg_if  cfg,
  output int   fails,
  output int   pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [DIM_BITS-1:0]  x;
    logic [DIM_BITS-1:0]  y;
    logic [7:0]           r;
    logic [7:0]           g;
    logic [7:0]           b;
    logic [ITER_BITS-1:0] count;
    logic                 in_set;
  } pixel_t;

  localparam logic signed [129:0] TOP = 130'sd9223372036854775807;
  localparam logic signed [129:0] BOT = -130'sd9223372036854775808;

  cfg_t   view;
  pixel_t expected_pixels[$];
  int     fail_count = 0;

  function automatic logic [63:0] clamp64(logic signed [129:0] v);
    if (v > TOP) return 64'h7FFF_FFFF_FFFF_FFFF;
    if (v < BOT) return 64'h8000_0000_0000_0000;
    return v[63:0];
  endfunction

  function automatic logic [63:0] map_point(logic [DIM_BITS-1:0] p, logic [SIZE_BITS-1:0] n,
                                            logic [62:0] step, logic [63:0] off);
    logic [13:0] nn;
    logic signed [15:0] d;
    logic [13:0] ad;
    logic [77:0] prod;
    logic [77:0] q;
    logic rem;
    logic signed [129:0] v;
    logic signed [129:0] o;
    nn = (n == 0) ? 14'd1 : {1'b0, n};
    d = $signed({3'b000, p, 1'b0}) - $signed({2'b00, nn});
    ad = d[15] ? 14'(-d) : 14'(d);
    prod = ad * step;
    q = prod / nn;
    rem = (prod % nn) != 0;
    v = $signed({52'd0, q});
    if (d[15]) v = -(v + $signed({129'd0, rem}));
    o = {{66{off[63]}}, off};
    return clamp64(v + o);
  endfunction

  function automatic logic [63:0] sq(logic [63:0] v);
    logic [63:0] m;
    logic [127:0] p;
    m = v[63] ? (~v + 64'd1) : v;
    p = m * m;
    p = p >> 58;
    if (p[127:64] != 0) return '1;
    return p[63:0];
  endfunction

  function automatic logic [63:0] cross2(logic [63:0] a, logic [63:0] b);
    logic [63:0] ma;
    logic [63:0] mb;
    logic [127:0] p;
    logic signed [129:0] v;
    ma = a[63] ? (~a + 64'd1) : a;
    mb = b[63] ? (~b + 64'd1) : b;
    p = ma * mb;
    v = $signed({2'b00, p >> 57});
    if (a[63] != b[63]) v = -(v + $signed({129'd0, p[56:0] != 0}));
    return clamp64(v);
  endfunction

  function automatic logic [7:0] shade(int k, longint lim, longint n);
    longint den;
    den = k * lim - 10 * n;
    if (den < 0) den = -den;
    if (den == 0) return 8'd0;
    return 8'((2550 * lim) / den);
  endfunction

  function automatic pixel_t escape_pixel(logic [DIM_BITS-1:0] px, logic [DIM_BITS-1:0] py);
    pixel_t e;
    logic [63:0] cx;
    logic [63:0] cy;
    logic [63:0] zx;
    logic [63:0] zy;
    logic [63:0] sx;
    logic [63:0] sy;
    logic [63:0] nx;
    logic [63:0] cr;
    longint n;
    longint lim;
    cx = map_point(px, view.width, view.step_x, view.x_off);
    cy = map_point(py, view.height, view.step_y, view.y_off);
    zx = 0;
    zy = 0;
    n = 0;
    lim = view.max_iter;
    while (n < lim) begin
      sx = sq(zx);
      sy = sq(zy);
      if ({1'b0, sx} + {1'b0, sy} >= (65'd1 << 60)) break;
      nx = clamp64($signed({66'd0, sx}) - $signed({66'd0, sy})
                   + $signed({{66{cx[63]}}, cx}));
      cr = cross2(zx, zy);
      zy = clamp64($signed({{66{cy[63]}}, cy}) + $signed({{66{cr[63]}}, cr}));
      zx = nx;
      n++;
    end
    e.x = px;
    e.y = py;
    e.in_set = (n == lim);
    e.count = n[ITER_BITS-1:0];
    e.r = e.in_set ? 8'd0 : shade(9, lim, n);
    e.g = e.in_set ? 8'd0 : shade(3, lim, n);
    e.b = e.in_set ? 8'd0 : shade(6, lim, n);
    return e;
  endfunction

  task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    pixel_t e;
    if (rst) begin
      view.width    <= 13'd800;
      view.height   <= 13'd600;
      view.max_iter <= 16'd256;
      view.x_off    <= -64'sd144115188075855872;
      view.y_off    <= 64'd0;
      view.step_x   <= 63'd1029394200541827657;
      view.step_y   <= 63'd772045650406370742;
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          REG_WIDTH:    view.width    <= cfg.data[SIZE_BITS-1:0];
          REG_HEIGHT:   view.height   <= cfg.data[SIZE_BITS-1:0];
          REG_MAX_ITER: view.max_iter <= cfg.data[ITER_BITS-1:0];
          REG_X_OFFSET: view.x_off    <= cfg.data;
          REG_Y_OFFSET: view.y_off    <= cfg.data;
          REG_STEP_X:   view.step_x   <= cfg.data[62:0];
          REG_STEP_Y:   view.step_y   <= cfg.data[62:0];
          default: ;
        endcase
      end
      if (pix.valid && pix.ready) expected_pixels.push_back(escape_pixel(pix.pixel_x, pix.pixel_y));
      if (res.valid && res.ready) begin
        if (expected_pixels.size() == 0) begin
          $display("%0t: unexpected result beat, expected none, actual x=%0d y=%0d",
                   $time, res.out_x, res.out_y);
          fail_count++;
        end else begin
          e = expected_pixels.pop_front();
          check_field("out_x", 16'(e.x), 16'(res.out_x));
          check_field("out_y", 16'(e.y), 16'(res.out_y));
          check_field("red", 16'(e.r), 16'(res.red));
          check_field("green", 16'(e.g), 16'(res.green));
          check_field("blue", 16'(e.b), 16'(res.blue));
          check_field("iteration_count", e.count, res.iteration_count);
          check_field("inside_set", 16'(e.in_set), 16'(res.inside_set));
        end
      end
    end
  end

  assign fails   = fail_count;
  assign pending = expected_pixels.size();

endmodule

### verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// Stimulus for the fractal pixel engine: directed views covering size, limit
// and offset extremes, then random views and pixels with random idle gaps on
// requests and back pressure on results. Checking is done by the checker.
// ----------------------------------------------------------------------------
module tb;
  import etfp_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint CYCLE_LIMIT = 6000000;
  localparam logic [63:0] ONE = 64'h0400_0000_0000_0000;
  localparam logic [63:0] POS_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] NEG_MAX = 64'h8000_0000_0000_0000;

  logic clk = 0;
  logic rst = 1;
  int   fails;
  int   pending;
  bit   calm = 0;
  int   hold = 0;
  longint cycles = 0;

  etfp_pix_if pix();
  etfp_res_if res();
  etfp_cfg_if cfg();

  escape_time_fractal_pixel_top dut (.clk(clk), .rst(rst), .pix(pix), .res(res), .cfg(cfg));

  pixel_color_checker u_checker (.clk(clk), .rst(rst), .pix(pix), .res(res), .cfg(cfg),
                                 .fails(fails), .pending(pending));

  always #5 clk = ~clk;

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      res.ready <= 1'b0;
      hold <= 0;
    end else if (hold != 0) begin
      hold <= hold - 1;
      res.ready <= 1'b0;
    end else if (!calm && $urandom_range(0, 5) == 0) begin
      hold <= gap_len();
      res.ready <= 1'b0;
    end else begin
      res.ready <= 1'b1;
    end
  end

  task automatic send_pixel(logic [DIM_BITS-1:0] x, logic [DIM_BITS-1:0] y);
    int g;
    g = gap_len();
    if (g != 0) begin
      pix.valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    pix.valid <= 1'b1;
    pix.pixel_x <= x;
    pix.pixel_y <= y;
    do @(posedge clk); while (!pix.ready);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [63:0] value);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data <= value;
    do @(posedge clk); while (!cfg.ready);
  endtask

  // drain, then program a whole view
  task automatic set_view(logic [63:0] w, logic [63:0] h, logic [63:0] lim,
                          logic [63:0] xo, logic [63:0] yo, logic [63:0] sx, logic [63:0] sy);
    pix.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    write_reg(REG_WIDTH, w);
    write_reg(REG_HEIGHT, h);
    write_reg(REG_MAX_ITER, lim);
    write_reg(REG_X_OFFSET, xo);
    write_reg(REG_Y_OFFSET, yo);
    write_reg(REG_STEP_X, sx);
    write_reg(REG_STEP_Y, sy);
    cfg.valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [63:0] pick_size();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 64);
    if (r < 85) return $urandom_range(65, 4096);
    case ($urandom_range(0, 3))
      0: return 0;
      1: return 1;
      2: return 4096;
      default: return 8191;
    endcase
  endfunction

  function automatic logic [63:0] pick_offset();
    longint v;
    if ($urandom_range(0, 9) == 0) return {$urandom, $urandom};
    v = longint'($urandom_range(0, 4000)) - 2500;
    return v * longint'(ONE / 1000);
  endfunction

  function automatic logic [63:0] pick_step(logic [63:0] n);
    if ($urandom_range(0, 9) == 0) return {$urandom, $urandom};
    if (n == 0) n = 1;
    return ((64'd1 << 59) / n) >> $urandom_range(0, 8);
  endfunction

  function automatic logic [DIM_BITS-1:0] pick_coord(logic [63:0] n);
    if ($urandom_range(0, 4) == 0 || n > 4095) return $urandom_range(0, 4095);
    return $urandom_range(0, n);
  endfunction

  initial begin
    logic [63:0] w;
    logic [63:0] h;
    logic [63:0] lim;
    int r;
    pix.valid <= 1'b0;
    pix.pixel_x <= '0;
    pix.pixel_y <= '0;
    cfg.valid <= 1'b0;
    cfg.index <= REG_WIDTH;
    cfg.data <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // view after reset, center pixel lies inside the set
    send_pixel(0, 0);
    send_pixel(400, 300);
    send_pixel(799, 599);
    send_pixel(800, 600);
    send_pixel(4095, 4095);

    // zero sizes and zero limit
    set_view(0, 0, 0, 0, 0, ONE, ONE);
    send_pixel(0, 0);
    send_pixel(4095, 0);

    // largest width, height 4096, limit one, saturating offsets and steps
    set_view(8191, 4096, 1, POS_MAX, NEG_MAX, POS_MAX, POS_MAX);
    send_pixel(0, 0);
    send_pixel(4095, 4095);
    send_pixel(2000, 7);
    set_view(1, 1, 2, NEG_MAX, POS_MAX, 0, 0);
    send_pixel(0, 4095);

    // highest limit with a point that leaves at once
    set_view(1, 1, 65535, 3 * ONE, 0, 0, 0);
    send_pixel(0, 0);
    send_pixel(4095, 4095);

    for (int ph = 0; ph < 30; ph++) begin
      w = pick_size();
      h = ($urandom_range(0, 1) == 0) ? w : pick_size();
      r = $urandom_range(0, 99);
      if (r < 75) lim = $urandom_range(1, 40);
      else if (r < 95) lim = $urandom_range(41, 200);
      else lim = $urandom_range(0, 1);
      set_view(w, h, lim, pick_offset(), pick_offset(), pick_step(w), pick_step(h));
      calm = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < 30; i++) send_pixel(pick_coord(w), pick_coord(h));
    end

    pix.valid <= 1'b0;
    calm = 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (fails == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
